// ----- sv/sha256_block_compression_top_macros.svh -----
// Assertion macros used by the checker file.
`ifndef SHA256_BLOCK_COMPRESSION_TOP_MACROS_SVH
`define SHA256_BLOCK_COMPRESSION_TOP_MACROS_SVH

// Concurrent assertion, disabled while reset is held.
`define SHA_ASSERT_RST(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("assertion failed");

// Concurrent assertion, checked during reset as well.
`define SHA_ASSERT(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) else $error("assertion failed");

`endif

// ----- sv/sha256bc_pkg.sv -----
package sha256bc_pkg;

  localparam int WORDS_PER_BLOCK = 16;
  localparam int ROUNDS          = 64;
  localparam int HASH_WORDS      = 8;
  localparam int WORD_CNT_W      = $clog2(WORDS_PER_BLOCK);
  localparam int ROUND_CNT_W     = $clog2(ROUNDS);
  localparam int OUT_IDX_W       = $clog2(HASH_WORDS);

  localparam logic [WORD_CNT_W-1:0]  WORD_LAST  = WORD_CNT_W'(WORDS_PER_BLOCK - 1);
  localparam logic [ROUND_CNT_W-1:0] ROUND_LAST = ROUND_CNT_W'(ROUNDS - 1);
  localparam logic [OUT_IDX_W-1:0]   OUT_LAST   = OUT_IDX_W'(HASH_WORDS - 1);

  typedef logic [31:0] word_t;
  typedef logic [0:HASH_WORDS-1][31:0] hash_t;

  typedef struct packed {
    word_t message_word;
    logic  final_block;
  } in_beat_t;

  typedef struct packed {
    word_t digest_word;
    logic  digest_last;
  } out_beat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                   in_ready;
    logic                   blk_load;
    logic                   wv_load;
    logic                   round_en;
    logic                   add_en;
    logic                   out_valid;
    logic                   out_last;
    logic [OUT_IDX_W-1:0]   out_idx;
    logic [ROUND_CNT_W-1:0] round_idx;
  } ctrl_t;

  localparam hash_t HASH_IV = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t bsig0(word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t ssig0(word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t ch(word_t x, word_t y, word_t z);
    return (x & y) ^ (~x & z);
  endfunction

  function automatic word_t maj(word_t x, word_t y, word_t z);
    return (x & y) ^ (x & z) ^ (y & z);
  endfunction

endpackage

// ----- sv/sha256bc_ctrl.sv -----
module sha256bc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 final_block,
  input  logic                 out_stall,
  output sha256bc_pkg::ctrl_t  ctl
);

  sha256bc_pkg::state_t state_r, state_nxt;
  logic [sha256bc_pkg::WORD_CNT_W-1:0]  word_cnt_r, word_cnt_nxt;
  logic [sha256bc_pkg::ROUND_CNT_W-1:0] round_cnt_r, round_cnt_nxt;
  logic [sha256bc_pkg::OUT_IDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic                                 final_r, final_nxt;
  logic                                 in_acc;
  logic                                 blk_done;
  logic                                 out_acc;

  assign in_acc   = in_valid && (state_r == sha256bc_pkg::ST_IDLE);
  assign blk_done = in_acc && (word_cnt_r == sha256bc_pkg::WORD_LAST);
  assign out_acc  = (state_r == sha256bc_pkg::ST_OUT) && !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sha256bc_pkg::ST_IDLE: begin
        if (blk_done) state_nxt = sha256bc_pkg::ST_ROUND;
      end
      sha256bc_pkg::ST_ROUND: begin
        if (round_cnt_r == sha256bc_pkg::ROUND_LAST) state_nxt = sha256bc_pkg::ST_ADD;
      end
      sha256bc_pkg::ST_ADD: begin
        state_nxt = final_r ? sha256bc_pkg::ST_OUT : sha256bc_pkg::ST_IDLE;
      end
      sha256bc_pkg::ST_OUT: begin
        if (out_acc && (out_idx_r == sha256bc_pkg::OUT_LAST)) state_nxt = sha256bc_pkg::ST_IDLE;
      end
      default: state_nxt = sha256bc_pkg::ST_IDLE;
    endcase
  end

  // advance counters, latch final flag with the last word of a block
  always_comb begin
    word_cnt_nxt  = in_acc ? word_cnt_r + 1'b1 : word_cnt_r;
    round_cnt_nxt = (state_r == sha256bc_pkg::ST_ROUND) ? round_cnt_r + 1'b1 : round_cnt_r;
    out_idx_nxt   = out_acc ? out_idx_r + 1'b1 : out_idx_r;
    final_nxt     = blk_done ? final_block : final_r;
  end

  // outputs
  always_comb begin
    ctl           = '0;
    ctl.in_ready  = (state_r == sha256bc_pkg::ST_IDLE);
    ctl.blk_load  = in_acc;
    ctl.wv_load   = blk_done;
    ctl.round_en  = (state_r == sha256bc_pkg::ST_ROUND);
    ctl.add_en    = (state_r == sha256bc_pkg::ST_ADD);
    ctl.out_valid = (state_r == sha256bc_pkg::ST_OUT);
    ctl.out_last  = (out_idx_r == sha256bc_pkg::OUT_LAST);
    ctl.out_idx   = out_idx_r;
    ctl.round_idx = round_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha256bc_pkg::ST_IDLE;
      word_cnt_r  <= '0;
      round_cnt_r <= '0;
      out_idx_r   <= '0;
      final_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      word_cnt_r  <= word_cnt_nxt;
      round_cnt_r <= round_cnt_nxt;
      out_idx_r   <= out_idx_nxt;
      final_r     <= final_nxt;
    end
  end

endmodule

// ----- sv/sha256bc_sched.sv -----
module sha256bc_sched (
  input  logic                clk,
  input  logic                blk_load,
  input  logic                round_en,
  input  sha256bc_pkg::word_t word_in,
  output sha256bc_pkg::word_t w_out
);

  sha256bc_pkg::word_t w_r   [sha256bc_pkg::WORDS_PER_BLOCK];
  sha256bc_pkg::word_t w_nxt [sha256bc_pkg::WORDS_PER_BLOCK];
  sha256bc_pkg::word_t w_new;

  // expand the next schedule word from the current window
  assign w_new = w_r[0] + sha256bc_pkg::ssig0(w_r[1]) + w_r[9] + sha256bc_pkg::ssig1(w_r[14]);

  // shift the window: message words while loading, expanded words while rounding
  always_comb begin
    for (int i = 0; i < sha256bc_pkg::WORDS_PER_BLOCK - 1; i++) begin
      w_nxt[i] = w_r[i+1];
    end
    w_nxt[sha256bc_pkg::WORDS_PER_BLOCK-1] = blk_load ? word_in : w_new;
  end

  always_ff @(posedge clk) begin
    if (blk_load || round_en) begin
      w_r <= w_nxt;
    end
  end

  assign w_out = w_r[0];

endmodule

// ----- sv/sha256bc_round.sv -----
module sha256bc_round (
  input  logic                clk,
  input  logic                wv_load,
  input  logic                round_en,
  input  sha256bc_pkg::hash_t chain_in,
  input  sha256bc_pkg::word_t k_in,
  input  sha256bc_pkg::word_t w_in,
  output sha256bc_pkg::hash_t wv_out
);

  sha256bc_pkg::hash_t wv_r, wv_nxt;
  sha256bc_pkg::word_t t1, t2;

  // one compression round on a..h
  always_comb begin
    t1 = wv_r[7] + sha256bc_pkg::bsig1(wv_r[4])
       + sha256bc_pkg::ch(wv_r[4], wv_r[5], wv_r[6]) + k_in + w_in;
    t2 = sha256bc_pkg::bsig0(wv_r[0]) + sha256bc_pkg::maj(wv_r[0], wv_r[1], wv_r[2]);
    wv_nxt    = wv_r;
    wv_nxt[7] = wv_r[6];
    wv_nxt[6] = wv_r[5];
    wv_nxt[5] = wv_r[4];
    wv_nxt[4] = wv_r[3] + t1;
    wv_nxt[3] = wv_r[2];
    wv_nxt[2] = wv_r[1];
    wv_nxt[1] = wv_r[0];
    wv_nxt[0] = t1 + t2;
  end

  always_ff @(posedge clk) begin
    if (wv_load) begin
      wv_r <= chain_in;
    end else if (round_en) begin
      wv_r <= wv_nxt;
    end
  end

  assign wv_out = wv_r;

endmodule

// ----- sv/sha256_block_compression_top.sv -----
// SHA-256 block compression engine. Feed the padded message as 32-bit big-endian words,
// one beat per cycle while in_stall is low; every sixteen words form one block. The
// sixteenth word starts compression: the block stalls its input during the rounds (one round
// per cycle through the single round unit, fed by a 16-word rolling schedule window) and
// the chaining add. If final_block is set on the sixteenth word, eight digest beats follow,
// word 0 first, digest_last on the eighth, at one per cycle unless out_stall holds them;
// the input stays stalled until the eighth beat is taken, and the chaining words then
// return to the initial values. final_block on other words is ignored.
module sha256_block_compression_top (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  sha256bc_pkg::in_beat_t  in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output sha256bc_pkg::out_beat_t out_data
);

  sha256bc_pkg::ctrl_t ctl;
  sha256bc_pkg::hash_t chain_r, chain_nxt;
  sha256bc_pkg::hash_t wv;
  sha256bc_pkg::word_t w_cur;
  sha256bc_pkg::word_t k_cur;

  sha256bc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .final_block (in_data.final_block),
    .out_stall   (out_stall),
    .ctl         (ctl)
  );

  sha256bc_sched u_sched (
    .clk      (clk),
    .blk_load (ctl.blk_load),
    .round_en (ctl.round_en),
    .word_in  (in_data.message_word),
    .w_out    (w_cur)
  );

  assign k_cur = sha256bc_pkg::ROUND_K[ctl.round_idx];

  sha256bc_round u_round (
    .clk      (clk),
    .wv_load  (ctl.wv_load),
    .round_en (ctl.round_en),
    .chain_in (chain_r),
    .k_in     (k_cur),
    .w_in     (w_cur),
    .wv_out   (wv)
  );

  // fold the working words into the chain; drop back to the IV after the last digest beat
  always_comb begin
    chain_nxt = chain_r;
    if (ctl.add_en) begin
      for (int i = 0; i < sha256bc_pkg::HASH_WORDS; i++) begin
        chain_nxt[i] = chain_r[i] + wv[i];
      end
    end else if (ctl.out_valid && !out_stall && ctl.out_last) begin
      chain_nxt = sha256bc_pkg::HASH_IV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= sha256bc_pkg::HASH_IV;
    end else begin
      chain_r <= chain_nxt;
    end
  end

  // drive the handshakes and the digest beat
  assign in_stall             = !ctl.in_ready;
  assign out_valid            = ctl.out_valid;
  assign out_data.digest_word = chain_r[ctl.out_idx];
  assign out_data.digest_last = ctl.out_last;

endmodule

// ----- sv/sha256bc_checker.sv -----
`include "sha256_block_compression_top_macros.svh"

module sha256bc_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input sha256bc_pkg::in_beat_t  in_data,
  input logic                    out_valid,
  input logic                    out_stall,
  input sha256bc_pkg::out_beat_t out_data
);

  logic in_acc_seen;

  assign in_acc_seen = in_valid && !in_stall && (in_data.final_block || !in_data.final_block);

  // a stalled digest beat holds its payload
  `SHA_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data))

  // no input is taken while digest beats are pending
  `SHA_ASSERT_RST(a_busy_on_out, clk, rst_n, out_valid |-> in_stall && !in_acc_seen)

  // the beat marked last closes the digest
  `SHA_ASSERT_RST(a_last_ends, clk, rst_n, out_valid && !out_stall && out_data.digest_last |=> !out_valid)

  // no digest beat right after reset
  `SHA_ASSERT(a_reset_quiet, clk, !rst_n |=> !out_valid)

endmodule

bind sha256_block_compression_top sha256bc_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- tb/sv/sha256_block_compression_top_tb.sv -----
module sha256_block_compression_top_tb;

  localparam int QUIET_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 120;
  localparam int MAX_REPORTS   = 10;
  localparam int WORDS_PER_RUN = 69;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  logic                    in_stall;
  sha256bc_pkg::in_beat_t  in_data   = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  sha256bc_pkg::out_beat_t out_data;

  sha256_block_compression_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // Pending message words and predicted digest beats
  sha256bc_pkg::in_beat_t  word_q[$];
  sha256bc_pkg::out_beat_t digest_q[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int n_pushed       = 0;
  int n_words        = 0;
  int n_blocks       = 0;
  int n_messages     = 0;
  int n_digest       = 0;
  int n_bad          = 0;
  int quiet_cycles   = 0;

  // Predictor state: chaining words, block buffer, fill position
  sha256bc_pkg::word_t chain_h [sha256bc_pkg::HASH_WORDS];
  sha256bc_pkg::word_t blk_w   [sha256bc_pkg::WORDS_PER_BLOCK];
  int                  fill_idx;

  function automatic sha256bc_pkg::word_t rot_right(sha256bc_pkg::word_t x, int unsigned n);
    logic [63:0] dbl;
    dbl = {x, x} >> n;
    return dbl[31:0];
  endfunction

  // Expand the schedule, run all rounds, fold into the chaining words
  function automatic void compress_buffer();
    sha256bc_pkg::word_t sched [sha256bc_pkg::ROUNDS];
    sha256bc_pkg::word_t v     [sha256bc_pkg::HASH_WORDS];
    sha256bc_pkg::word_t t1, t2, s0, s1;
    for (int i = 0; i < sha256bc_pkg::WORDS_PER_BLOCK; i++) sched[i] = blk_w[i];
    for (int i = sha256bc_pkg::WORDS_PER_BLOCK; i < sha256bc_pkg::ROUNDS; i++) begin
      s0 = rot_right(sched[i-15], 7) ^ rot_right(sched[i-15], 18) ^ (sched[i-15] >> 3);
      s1 = rot_right(sched[i-2], 17) ^ rot_right(sched[i-2], 19) ^ (sched[i-2] >> 10);
      sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
    end
    for (int j = 0; j < sha256bc_pkg::HASH_WORDS; j++) v[j] = chain_h[j];
    for (int i = 0; i < sha256bc_pkg::ROUNDS; i++) begin
      t1 = v[7] + (rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256bc_pkg::ROUND_K[i] + sched[i];
      t2 = (rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int j = 0; j < sha256bc_pkg::HASH_WORDS; j++) chain_h[j] = chain_h[j] + v[j];
  endfunction

  // Take one accepted word; on a closing block, predict the eight digest beats
  function automatic void absorb_word(sha256bc_pkg::in_beat_t b);
    sha256bc_pkg::out_beat_t d;
    blk_w[fill_idx] = b.message_word;
    if (fill_idx != sha256bc_pkg::WORDS_PER_BLOCK - 1) begin
      fill_idx++;
      return;
    end
    fill_idx = 0;
    n_blocks++;
    compress_buffer();
    if (b.final_block) begin
      n_messages++;
      for (int j = 0; j < sha256bc_pkg::HASH_WORDS; j++) begin
        d.digest_word = chain_h[j];
        d.digest_last = (j == sha256bc_pkg::HASH_WORDS - 1);
        digest_q.push_back(d);
      end
      for (int j = 0; j < sha256bc_pkg::HASH_WORDS; j++) chain_h[j] = sha256bc_pkg::HASH_IV[j];
    end
  endfunction

  task automatic queue_word(sha256bc_pkg::word_t w, logic f);
    word_q.push_back(sha256bc_pkg::in_beat_t'{message_word: w, final_block: f});
    n_pushed++;
  endtask

  // Bias toward all-zero and all-one words
  function automatic sha256bc_pkg::word_t pick_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Close about half the blocks; scatter stray final flags mid-block
  function automatic logic pick_flag();
    if ((n_pushed % sha256bc_pkg::WORDS_PER_BLOCK) == sha256bc_pkg::WORDS_PER_BLOCK - 1)
      return 1'($urandom_range(1));
    return ($urandom_range(4) == 0);
  endfunction

  task automatic report_mismatch(string msg);
    n_bad++;
    if (n_bad <= MAX_REPORTS) $display("MISMATCH: %s", msg);
  endtask

  // Driver: hold the beat while stalled, otherwise load the next or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        absorb_word(in_data);
        n_words++;
      end
      if (!in_valid || !in_stall) begin
        if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= word_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each digest beat against the oldest prediction
  always @(posedge clk) begin : monitor_blk
    sha256bc_pkg::out_beat_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_digest++;
        if (digest_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat word=%08h last=%0b",
                                    out_data.digest_word, out_data.digest_last));
        end else begin
          want = digest_q.pop_front();
          if (out_data.digest_word !== want.digest_word ||
              out_data.digest_last !== want.digest_last)
            report_mismatch($sformatf("word exp=%08h got=%08h, last exp=%0b got=%0b",
                                      want.digest_word, out_data.digest_word,
                                      want.digest_last, out_data.digest_last));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: abort when no beat moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int j = 0; j < sha256bc_pkg::HASH_WORDS; j++) chain_h[j] = sha256bc_pkg::HASH_IV[j];
    fill_idx = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Padded "abc" in one block; stray final flags on words 4 and 9 must be ignored
    for (int k = 0; k < sha256bc_pkg::WORDS_PER_BLOCK; k++)
      queue_word((k == 0) ? 32'h61626380 :
                 (k == sha256bc_pkg::WORDS_PER_BLOCK - 1) ? 32'h18 : 32'h0,
                 (k == 4) || (k == 9) || (k == sha256bc_pkg::WORDS_PER_BLOCK - 1));
    // Extreme and alternating patterns opening the next block
    queue_word(32'hffffffff, 1'b1);
    queue_word(32'h00000000, 1'b1);
    queue_word(32'haaaaaaaa, 1'b0);
    queue_word(32'h55555555, 1'b1);
    queue_word(32'h80000000, 1'b0);
    queue_word(32'h00000001, 1'b1);
    queue_word(32'hffffffff, 1'b0);
    queue_word(32'h00000000, 1'b0);
    queue_word(32'h7fffffff, 1'b1);
    while (n_words != n_pushed) @(posedge clk);

    // Random words under each idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      for (int k = 0; k < WORDS_PER_RUN; k++) queue_word(pick_word(), pick_flag());
      while (n_words != n_pushed) @(posedge clk);
    end

    // Drain remaining digests, then allow for any stray late beats
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words forming %0d blocks, %0d of them closing a message.",
             n_words, n_blocks, n_messages);
    $display("Checked %0d digest beats, %0d mismatches.", n_digest, n_bad);
    if (n_bad == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
